// ===== rtl/core/detpr_pkg.sv =====
package detpr_pkg;

  // Detector geometry.
  localparam int PIXELS_PER_CHIP   = 256;
  localparam int CHIPS_PER_BLOCK   = 4;
  localparam int BLOCKS_PER_STRIPE = 2;
  localparam int SUPERCOLUMN_WIDTH = 32;
  localparam int GROUP_SIX_BIT     = 4;
  localparam int GROUP_TWELVE_BIT  = 4;

  localparam int ROW_WIDTH   = PIXELS_PER_CHIP * CHIPS_PER_BLOCK * BLOCKS_PER_STRIPE;
  localparam int BLOCK_WIDTH = PIXELS_PER_CHIP * CHIPS_PER_BLOCK;
  localparam int SC_PER_CHIP = (PIXELS_PER_CHIP / SUPERCOLUMN_WIDTH) > 0 ?
                               (PIXELS_PER_CHIP / SUPERCOLUMN_WIDTH) : 1;
  localparam int GROUPS6     = (PIXELS_PER_CHIP / GROUP_SIX_BIT) > 0 ?
                               (PIXELS_PER_CHIP / GROUP_SIX_BIT) : 1;
  localparam int GROUPS12    = (PIXELS_PER_CHIP / GROUP_TWELVE_BIT) > 0 ?
                               (PIXELS_PER_CHIP / GROUP_TWELVE_BIT) : 1;
  localparam int ROW_PAIRS   = (PIXELS_PER_CHIP / 2) > 0 ? (PIXELS_PER_CHIP / 2) : 1;

  // Position counter, address and frame length widths.
  localparam int POS_W    = 19;
  localparam int ADDR_W   = 19;
  localparam int LEN_W    = POS_W + 1;
  localparam int POS_SPAN = 2 ** POS_W;

  localparam int LEN_ONE_RAW    = BLOCKS_PER_STRIPE * PIXELS_PER_CHIP * SUPERCOLUMN_WIDTH;
  localparam int LEN_SIX_RAW    = BLOCKS_PER_STRIPE * ROW_PAIRS * GROUPS6 * CHIPS_PER_BLOCK *
                                  GROUP_SIX_BIT * 2;
  localparam int LEN_TWELVE_RAW = BLOCKS_PER_STRIPE * PIXELS_PER_CHIP * GROUPS12 *
                                  CHIPS_PER_BLOCK * GROUP_TWELVE_BIT;
  localparam int LEN_ONE    = (LEN_ONE_RAW > POS_SPAN || LEN_ONE_RAW == 0) ?
                              POS_SPAN : LEN_ONE_RAW;
  localparam int LEN_SIX    = (LEN_SIX_RAW > POS_SPAN || LEN_SIX_RAW == 0) ?
                              POS_SPAN : LEN_SIX_RAW;
  localparam int LEN_TWELVE = (LEN_TWELVE_RAW > POS_SPAN || LEN_TWELVE_RAW == 0) ?
                              POS_SPAN : LEN_TWELVE_RAW;

  // One-bit mode: one beat per chip and supercolumn, at most one per word bit.
  localparam int ONE_BIT_BEATS_RAW = CHIPS_PER_BLOCK * SC_PER_CHIP;
  localparam int ONE_BIT_BEATS     = ONE_BIT_BEATS_RAW > 32 ? 32 : ONE_BIT_BEATS_RAW;
  localparam int BEAT_W            = ONE_BIT_BEATS > 1 ? $clog2(ONE_BIT_BEATS) : 1;

  // High-half store.
  localparam int HALF_W      = 12;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  // Payload widths.
  localparam int RAW_W   = 32;
  localparam int FNUM_W  = 32;
  localparam int VALUE_W = 24;
  localparam int DEPTH_W = 2;

  typedef enum logic [DEPTH_W-1:0] {
    DEPTH_ONE         = 2'd0,
    DEPTH_SIX         = 2'd1,
    DEPTH_TWELVE      = 2'd2,
    DEPTH_TWENTY_FOUR = 2'd3
  } depth_t;

  localparam depth_t DEPTH_RESET = DEPTH_TWELVE;

  // One located word travelling from the position stage to the output stage.
  typedef struct packed {
    depth_t              depth;
    logic                write_store;
    logic                read_store;
    logic [ADDR_W-1:0]   addr;
    logic [RAW_W-1:0]    raw;
    logic [FNUM_W-1:0]   fnum;
  } item_t;

  function automatic logic [LEN_W-1:0] frame_len(input depth_t depth);
    logic [LEN_W-1:0] len;
    case (depth)
      DEPTH_ONE: len = LEN_W'(LEN_ONE);
      DEPTH_SIX: len = LEN_W'(LEN_SIX);
      default:   len = LEN_W'(LEN_TWELVE);
    endcase
    return len;
  endfunction

  // Twelve-bit order: pixel in group, chip, group, row, block.
  function automatic logic [ADDR_W-1:0] addr_twelve(input logic [POS_W-1:0] pos);
    logic [31:0] p;
    logic [31:0] x2;
    logic [31:0] chip;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] blk;
    logic [31:0] px;
    logic [31:0] py;
    p    = 32'(pos);
    x2   = p % GROUP_TWELVE_BIT;
    p    = p / GROUP_TWELVE_BIT;
    chip = p % CHIPS_PER_BLOCK;
    p    = p / CHIPS_PER_BLOCK;
    x    = p % GROUPS12;
    p    = p / GROUPS12;
    y    = p % PIXELS_PER_CHIP;
    blk  = p / PIXELS_PER_CHIP;
    px   = blk * BLOCK_WIDTH + chip * PIXELS_PER_CHIP +
           (32'(PIXELS_PER_CHIP - 1) - (x2 + x * GROUP_TWELVE_BIT));
    py   = 32'(PIXELS_PER_CHIP - 1) - y;
    return ADDR_W'(px + py * ROW_WIDTH);
  endfunction

  // Six-bit order: the lowest position bit picks one row of a row pair.
  function automatic logic [ADDR_W-1:0] addr_six(input logic [POS_W-1:0] pos);
    logic [31:0] p;
    logic        upper;
    logic [31:0] x2;
    logic [31:0] chip;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] blk;
    logic [31:0] px;
    logic [31:0] py;
    p     = 32'(pos);
    upper = p[0];
    p     = p >> 1;
    x2    = p % GROUP_SIX_BIT;
    p     = p / GROUP_SIX_BIT;
    chip  = p % CHIPS_PER_BLOCK;
    p     = p / CHIPS_PER_BLOCK;
    x     = p % GROUPS6;
    p     = p / GROUPS6;
    y     = (p % ROW_PAIRS) * 2;
    blk   = p / ROW_PAIRS;
    px    = blk * BLOCK_WIDTH + chip * PIXELS_PER_CHIP +
            (32'(PIXELS_PER_CHIP - 1) - (x2 + x * GROUP_SIX_BIT));
    py    = (upper ? 32'(PIXELS_PER_CHIP - 1) : 32'(PIXELS_PER_CHIP - 2)) - y;
    return ADDR_W'(px + py * ROW_WIDTH);
  endfunction

  // One-bit order: address of chip 0, supercolumn 0; each beat adds its own offset.
  function automatic logic [ADDR_W-1:0] addr_one_base(input logic [POS_W-1:0] pos);
    logic [31:0] p;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] blk;
    logic [31:0] px;
    logic [31:0] py;
    p   = 32'(pos);
    x   = p % SUPERCOLUMN_WIDTH;
    p   = p / SUPERCOLUMN_WIDTH;
    y   = p % PIXELS_PER_CHIP;
    blk = p / PIXELS_PER_CHIP;
    px  = blk * BLOCK_WIDTH + (32'(PIXELS_PER_CHIP - 1) - x);
    py  = 32'(PIXELS_PER_CHIP - 1) - y;
    return ADDR_W'(px + py * ROW_WIDTH);
  endfunction

  // Offset of one beat of a one-bit word from the base address.
  function automatic logic [ADDR_W-1:0] beat_offset(input logic [BEAT_W-1:0] beat);
    logic [31:0] b;
    logic [31:0] off;
    b   = 32'(beat);
    off = (b / SC_PER_CHIP) * PIXELS_PER_CHIP - (b % SC_PER_CHIP) * SUPERCOLUMN_WIDTH;
    return ADDR_W'(off);
  endfunction

endpackage

// ===== rtl/core/detector_pixel_reorder_top.sv =====
// Pixel reorder for detector readout. Raw words go in on the input channel and come
// out as (pixel_address, pixel_value, out_frame_id, last) beats on the output
// channel via the located-item and output stage registers. In six-, twelve- and
// twenty-four-bit modes one word is taken every cycle without out_stall; in one-bit
// mode each word makes 32 output beats, so the output port sets the pace. In
// twenty-four-bit mode the first frame of a pair is written into a 512K x 12 store
// and gives no beats; the second frame reads it back through the store's single
// port, one access per word, and merges the stored high half with the new low
// half. The store has no reset or clearing pass: a location must be written in
// the first frame of a pair before it is read. The user must write counter_depth
// through cfg_write and cfg_data while no word is in flight; it is not enforced.
module detector_pixel_reorder_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [detpr_pkg::DEPTH_W-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [detpr_pkg::RAW_W-1:0]      raw_word,
  input  logic                             frame_start,
  input  logic [detpr_pkg::FNUM_W-1:0]     frame_id,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [detpr_pkg::ADDR_W-1:0]     pixel_address,
  output logic [detpr_pkg::VALUE_W-1:0]    pixel_value,
  output logic [detpr_pkg::FNUM_W-1:0]     out_frame_id,
  output logic                             last
);

  detpr_pkg::depth_t             counter_depth;
  logic                          item_valid;
  detpr_pkg::item_t              item;
  logic                          take;
  logic                          out_free;
  logic                          out_load;
  logic                          beat_last;
  logic [detpr_pkg::HALF_W-1:0]  high_half;

  // Output stage registers.
  logic                          out_full;
  detpr_pkg::depth_t             out_depth;
  logic [detpr_pkg::ADDR_W-1:0]  out_addr;
  logic [detpr_pkg::RAW_W-1:0]   out_raw;
  logic [detpr_pkg::FNUM_W-1:0]  out_fnum;
  logic [detpr_pkg::BEAT_W-1:0]  beat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_depth <= detpr_pkg::DEPTH_RESET;
    end else if (cfg_write) begin
      counter_depth <= detpr_pkg::depth_t'(cfg_data);
    end
  end

  detpr_locate u_locate (
    .clk          (clk),
    .rst          (rst),
    .depth        (counter_depth),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_word     (raw_word),
    .frame_start  (frame_start),
    .frame_id     (frame_id),
    .take         (take),
    .item_valid   (item_valid),
    .item         (item)
  );

  // A store write needs no output slot; everything else waits for the output stage.
  assign beat_last = (out_depth != detpr_pkg::DEPTH_ONE) ||
                     (beat == detpr_pkg::BEAT_W'(detpr_pkg::ONE_BIT_BEATS - 1));
  assign out_free  = !out_full || (!out_stall && beat_last);
  assign take      = item_valid && (item.write_store || out_free);
  assign out_load  = take && !item.write_store;

  detpr_store u_store (
    .clk     (clk),
    .wr_en   (take && item.write_store),
    .rd_en   (take && item.read_store),
    .addr    (item.addr),
    .wr_data (item.raw[detpr_pkg::HALF_W-1:0]),
    .rd_data (high_half)
  );

  // Output stage control and beat counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
      beat     <= '0;
    end else if (out_load) begin
      out_full <= 1'b1;
      beat     <= '0;
    end else if (out_full && !out_stall) begin
      if (beat_last) begin
        out_full <= 1'b0;
      end else begin
        beat <= beat + detpr_pkg::BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_depth <= item.depth;
      out_addr  <= item.addr;
      out_raw   <= item.raw;
      out_fnum  <= item.fnum;
    end
  end

  // Beat payload.
  always_comb begin
    case (out_depth)
      detpr_pkg::DEPTH_ONE: begin
        pixel_address = out_addr + detpr_pkg::beat_offset(beat);
        pixel_value   = detpr_pkg::VALUE_W'(out_raw[beat]);
      end
      detpr_pkg::DEPTH_SIX: begin
        pixel_address = out_addr;
        pixel_value   = detpr_pkg::VALUE_W'(out_raw[7:0]);
      end
      detpr_pkg::DEPTH_TWELVE: begin
        pixel_address = out_addr;
        pixel_value   = detpr_pkg::VALUE_W'(out_raw[15:0]);
      end
      default: begin
        pixel_address = out_addr;
        pixel_value   = {high_half, out_raw[detpr_pkg::HALF_W-1:0]};
      end
    endcase
  end

  assign out_valid    = out_full;
  assign out_frame_id = out_fnum;
  assign last         = beat_last;

endmodule

// ===== rtl/core/detpr_store.sv =====
module detpr_store (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic                           rd_en,
  input  logic [detpr_pkg::ADDR_W-1:0]   addr,
  input  logic [detpr_pkg::HALF_W-1:0]   wr_data,
  output logic [detpr_pkg::HALF_W-1:0]   rd_data
);

  logic [detpr_pkg::HALF_W-1:0] mem [0:detpr_pkg::STORE_DEPTH-1];

  // Single port: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

// ===== rtl/core/detpr_locate.sv =====
module detpr_locate (
  input  logic                          clk,
  input  logic                          rst,
  input  detpr_pkg::depth_t             depth,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [detpr_pkg::RAW_W-1:0]   raw_word,
  input  logic                          frame_start,
  input  logic [detpr_pkg::FNUM_W-1:0]  frame_id,
  input  logic                          take,
  output logic                          item_valid,
  output detpr_pkg::item_t              item
);

  logic [detpr_pkg::POS_W-1:0] raw_position;
  logic [detpr_pkg::POS_W-1:0] raw_position_next;
  logic                        pair_phase;
  logic                        pair_phase_next;
  logic                        accept;
  logic [detpr_pkg::LEN_W-1:0] len;
  logic [detpr_pkg::POS_W-1:0] pos_start;
  logic [detpr_pkg::POS_W-1:0] pos;
  logic [detpr_pkg::LEN_W-1:0] pos_inc;
  detpr_pkg::item_t            item_next;

  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  // Position of this beat in the raw frame, and where the count goes after it.
  always_comb begin
    len       = detpr_pkg::frame_len(depth);
    pos_start = frame_start ? '0 : raw_position;
    pos       = ({1'b0, pos_start} >= len) ? '0 : pos_start;
    pos_inc   = {1'b0, pos} + detpr_pkg::LEN_W'(1);
    if (pos_inc >= len) begin
      raw_position_next = '0;
      pair_phase_next   = (depth == detpr_pkg::DEPTH_TWENTY_FOUR) ? !pair_phase : pair_phase;
    end else begin
      raw_position_next = pos_inc[detpr_pkg::POS_W-1:0];
      pair_phase_next   = pair_phase;
    end
  end

  // Pixel address and store access for this beat.
  always_comb begin
    item_next.depth       = depth;
    item_next.raw         = raw_word;
    item_next.write_store = (depth == detpr_pkg::DEPTH_TWENTY_FOUR) && !pair_phase;
    item_next.read_store  = (depth == detpr_pkg::DEPTH_TWENTY_FOUR) && pair_phase;
    item_next.fnum        = (depth == detpr_pkg::DEPTH_TWENTY_FOUR) ?
                            (frame_id >> 1) : frame_id;
    case (depth)
      detpr_pkg::DEPTH_ONE: item_next.addr = detpr_pkg::addr_one_base(pos);
      detpr_pkg::DEPTH_SIX: item_next.addr = detpr_pkg::addr_six(pos);
      default:              item_next.addr = detpr_pkg::addr_twelve(pos);
    endcase
  end

  // Counter state and the located-item register.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_position <= '0;
      pair_phase   <= 1'b0;
      item_valid   <= 1'b0;
    end else if (accept) begin
      raw_position <= raw_position_next;
      pair_phase   <= pair_phase_next;
      item_valid   <= 1'b1;
    end else if (take) begin
      item_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule
